// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned ALIGN_W = 27;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic         mode;
      logic [31:0]  byte_size;
      logic [26:0]  align_bytes;
      logic [31:0]  start_address;
   } req_beat_type;

endpackage

// ===== hdl/bpa_ram.sv =====
module bpa_ram
   import bpa_pkg::*;
#(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bitmap_page_allocator_unit.sv =====
// Bitmap page allocator: one used bit per page in a single-port-write memory,
// plus a next-fit cursor.
// req channel: one beat per request. tuser[0] = mode (0 allocate, 1 free);
//   tdata = byte_size, align_bytes, start_address from bit 0 up.
// rsp channel: one beat per request. tuser = status, tdata = page address.
// csr port: register 0 at byte address 0 is page_limit (15 bits).
// Allocate: each page examined is read from the memory, then evaluated,
//   scanning from the page after the cursor to the limit, then from page 0
//   to the cursor; then the requested pages are marked used one by one.
// Free: the pages are cleared one by one.
// One request is in flight at a time; req_tready is high only when idle.
// After reset the map is initialised by a pass over all TOTAL_PAGES pages
// (pages below KERNEL_PAGES marked used); no request is taken meanwhile.
// A stalled rsp beat holds; the next request may be accepted meanwhile and
// its result waits until the held beat is taken.
module bitmap_page_allocator_unit
   import bpa_pkg::*;
#(
   parameter int TOTAL_PAGES  = 16384,
   parameter int PAGE_BITS    = 12,
   parameter int KERNEL_PAGES = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // byte_size, align_bytes, start_address
   input  logic [0:0]    req_tuser,   // mode
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // page_address
   output logic [1:0]    rsp_tuser,   // status
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int IW  = $clog2(TOTAL_PAGES);
   localparam int PW  = IW + 1;
   localparam int CW  = 33 - PAGE_BITS;
   localparam int XW  = ((CW > PW) ? CW : PW) + 1;
   localparam int APW = ALIGN_W - PAGE_BITS;
   localparam int BOOT = (KERNEL_PAGES < TOTAL_PAGES) ? KERNEL_PAGES : TOTAL_PAGES;
   localparam int LIM_RST = (TOTAL_PAGES > 32767) ? 32767 : TOTAL_PAGES;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_EV   = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   req_beat_type req;
   assign req = {req_tuser[0], req_tdata[31:0], req_tdata[58:32], req_tdata[90:59]};

   logic [2:0]         state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [IW-1:0]      cursor_ff, cursor_in;
   logic [XW-1:0]      p_ff, p_in, f_ff, f_in, e_ff, e_in, mask_ff, mask_in;
   logic [XW-1:0]      cnt_ff, cnt_in, start_ff, start_in;
   logic [XW-1:0]      n_ff, n_in, w_ff, w_in;
   logic               phase_ff, phase_in, wval_ff, wval_in, alloc_ff, alloc_in;
   logic [1:0]         res_st_ff, res_st_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_st_ff, rsp_st_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   logic               ram_we, ram_wd, ram_rd;
   logic [IW-1:0]      ram_wa, ram_ra;

   logic [XW-1:0]      lim, cur_x, a_cnt, f_cnt, sp_x, al, c_val;
   logic [ADDR_W-1:0]  addr_x;
   logic [APW-1:0]     ap;
   logic               csr_wr;

   bpa_ram #(.WIDTH(1), .DEPTH(TOTAL_PAGES)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {{(32-LIMIT_W){1'b0}}, limit_ff} : 32'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_st_ff;

   always_comb begin
      lim   = (XW'(limit_ff) < XW'(TOTAL_PAGES)) ? XW'(limit_ff) : XW'(TOTAL_PAGES);
      cur_x = XW'(cursor_ff);
      a_cnt = XW'((({1'b0, req.byte_size}) + 33'((1 << PAGE_BITS) - 1)) >> PAGE_BITS);
      f_cnt = XW'(req.byte_size >> PAGE_BITS);
      sp_x  = XW'(req.start_address[ADDR_W-1:PAGE_BITS]);
      ap    = req.align_bytes[ALIGN_W-1:PAGE_BITS];
      al    = XW'(1);
      for (int i = 1; i < APW; i++) begin
         if (ap[i]) begin
            al = XW'(1) << i;
         end
      end
      c_val  = (f_ff + mask_ff) & ~mask_ff;
      addr_x = ADDR_W'(start_ff) << PAGE_BITS;
   end

   always_comb begin
      state_in    = state_ff;
      limit_in    = limit_ff;
      cursor_in   = cursor_ff;
      p_in        = p_ff;
      f_in        = f_ff;
      e_in        = e_ff;
      mask_in     = mask_ff;
      cnt_in      = cnt_ff;
      start_in    = start_ff;
      n_in        = n_ff;
      w_in        = w_ff;
      phase_in    = phase_ff;
      wval_in     = wval_ff;
      alloc_in    = alloc_ff;
      res_st_in   = res_st_ff;
      res_addr_in = res_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_addr_in = rsp_addr_ff;
      ram_we      = 1'b0;
      ram_wa      = w_ff[IW-1:0];
      ram_wd      = wval_ff;
      ram_ra      = p_ff[IW-1:0];

      if (csr_wr && csr_paddr[2] == 1'b0) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            ram_we  = 1'b1;
            ram_wd  = (w_ff < XW'(BOOT));
            w_in    = w_ff + XW'(1);
            if (w_ff == XW'(TOTAL_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            res_addr_in = '0;
            if (req_tvalid) begin
               state_in = S_OUT;
               if (req.mode == MODE_ALLOC) begin
                  alloc_in = 1'b1;
                  cnt_in   = a_cnt;
                  mask_in  = al - XW'(1);
                  phase_in = 1'b0;
                  p_in     = cur_x + XW'(1);
                  f_in     = cur_x + XW'(1);
                  e_in     = lim;
                  wval_in  = 1'b1;
                  if (a_cnt == '0) begin
                     res_st_in = ST_ZERO;
                  end else begin
                     state_in = S_CHK;
                  end
               end else begin
                  alloc_in  = 1'b0;
                  wval_in   = 1'b0;
                  w_in      = sp_x;
                  n_in      = f_cnt;
                  res_st_in = ST_DONE;
                  if (f_cnt == '0) begin
                     res_st_in = ST_ZERO;
                  end else if (sp_x + f_cnt > lim) begin
                     res_st_in = ST_FAIL;
                  end else begin
                     state_in = S_WR;
                  end
               end
            end
         end
         S_CHK: begin
            if (p_ff >= e_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  p_in     = '0;
                  f_in     = '0;
                  e_in     = (cur_x < lim) ? cur_x : lim;
               end else begin
                  res_st_in = ST_FAIL;
                  state_in  = S_OUT;
               end
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            state_in = S_CHK;
            p_in     = p_ff + XW'(1);
            if (ram_rd) begin
               f_in = p_ff + XW'(1);
            end else if (c_val <= p_ff && (p_ff - c_val + XW'(1)) >= cnt_ff) begin
               start_in = c_val;
               w_in     = c_val;
               n_in     = cnt_ff;
               state_in = S_WR;
            end
         end
         S_WR: begin
            ram_we = 1'b1;
            w_in   = w_ff + XW'(1);
            n_in   = n_ff - XW'(1);
            if (n_ff == XW'(1)) begin
               state_in  = S_OUT;
               res_st_in = ST_DONE;
               if (alloc_ff) begin
                  cursor_in   = w_ff[IW-1:0];
                  res_addr_in = addr_x;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_addr_in  = res_addr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         limit_ff     <= LIMIT_W'(LIM_RST);
         cursor_ff    <= IW'(BOOT - 1);
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         cursor_ff    <= cursor_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      f_ff        <= f_in;
      e_ff        <= e_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
      start_ff    <= start_in;
      n_ff        <= n_in;
      phase_ff    <= phase_in;
      wval_ff     <= wval_in;
      alloc_ff    <= alloc_in;
      res_st_ff   <= res_st_in;
      res_addr_ff <= res_addr_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   a_init_no_req: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !req_tready)
      else $error("request taken during map initialisation");

   a_we_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_INIT || state_ff == S_WR))
      else $error("map written outside init or write phase");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_st_ff != 2'd3)
      else $error("undefined status code");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      XW'(cursor_ff) < XW'(TOTAL_PAGES))
      else $error("cursor beyond map");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_st_ff != ST_DONE) |-> rsp_addr_ff == '0)
      else $error("address on failed response");

endmodule

// ===== tb/tb.sv =====
module tb;
   import bpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_PAGES   = 16384;
   localparam int PG_BITS     = 12;
   localparam int BOOT_PAGES  = 4096;
   localparam int MAX_CYCLES  = 20000000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [2:0] REG_PAGE_LIMIT = 3'd0;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] page_address;
   } grant_type;

   typedef struct {
      logic        mode;
      logic [31:0] byte_size;
      logic [26:0] align_bytes;
      logic [31:0] start_address;
      bit          fixed;
      grant_type   fixed_grant;
   } dir_row_type;

   typedef struct {
      int unsigned limit;
      int          items;
      int          idling;
      bit          noisy;
   } phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bit          used_map [MAP_PAGES];
   longint unsigned next_fit;
   longint unsigned page_limit_reg;
   grant_type   pending_grants [$];
   bit          failed = 1'b0;
   int          idling = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   longint      cycle_count = 0;

   bitmap_page_allocator_unit u_top (.*);

   always #2 clock = ~clock;

   function automatic bit find_free_run(longint unsigned cnt, longint unsigned s,
                                        longint unsigned e, longint unsigned al,
                                        output longint unsigned found);
      longint unsigned mask, f, c;
      mask  = al - 1;
      f     = s;
      found = 0;
      if (e > MAP_PAGES) e = MAP_PAGES;
      for (longint unsigned p = s; p < e; p++) begin
         if (used_map[p]) begin
            f = p + 1;
            continue;
         end
         c = (f + mask) & ~mask;
         if (c <= p && p - c + 1 >= cnt) begin
            found = c;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic grant_type serve_request(logic mode, logic [31:0] size,
                                               logic [26:0] alb, logic [31:0] saddr);
      grant_type g;
      longint unsigned lim, cnt, ap, al, start, sp;
      bit ok;
      g   = '{ST_DONE, 32'd0};
      lim = (page_limit_reg < MAP_PAGES) ? page_limit_reg : MAP_PAGES;
      if (mode == MODE_ALLOC) begin
         cnt = (longint'(size) + 4095) >> PG_BITS;
         if (cnt == 0) begin
            g.status = ST_ZERO;
            return g;
         end
         ap = alb >> PG_BITS;
         al = 1;
         while (ap > 1) begin
            ap >>= 1;
            al <<= 1;
         end
         ok = find_free_run(cnt, next_fit + 1, lim, al, start);
         if (!ok) ok = find_free_run(cnt, 0, (next_fit < lim) ? next_fit : lim, al, start);
         if (!ok) begin
            g.status = ST_FAIL;
            return g;
         end
         for (longint unsigned i = 0; i < cnt; i++) used_map[start + i] = 1'b1;
         next_fit       = start + cnt - 1;
         g.page_address = 32'(start << PG_BITS);
      end else begin
         cnt = longint'(size) >> PG_BITS;
         sp  = longint'(saddr) >> PG_BITS;
         if (cnt == 0) begin
            g.status = ST_ZERO;
            return g;
         end
         if (sp + cnt > lim) begin
            g.status = ST_FAIL;
            return g;
         end
         for (longint unsigned i = 0; i < cnt; i++) used_map[sp + i] = 1'b0;
      end
      return g;
   endfunction

   dir_row_type directed_rows [12] = '{
      '{MODE_ALLOC, 32'd0,          27'd0,         32'd0,          1'b1, '{ST_ZERO, 32'd0}},
      '{MODE_FREE,  32'h0000_0FFF,  27'd0,         32'h0000_5000,  1'b1, '{ST_ZERO, 32'd0}},
      '{MODE_ALLOC, 32'd1,          27'd0,         32'd0,          1'b1,
        '{ST_DONE, 32'h0100_0000}},
      '{MODE_ALLOC, 32'h0000_4000,  27'h000_4000,  32'd0,          1'b0, '{ST_DONE, 32'd0}},
      '{MODE_ALLOC, 32'hFFFF_FFFF,  27'h7FF_FFFF,  32'd0,          1'b1, '{ST_FAIL, 32'd0}},
      '{MODE_FREE,  32'hFFFF_FFFF,  27'h7FF_FFFF,  32'hFFFF_FFFF,  1'b1, '{ST_FAIL, 32'd0}},
      '{MODE_FREE,  32'h0000_2000,  27'd0,         32'h0000_0000,  1'b1, '{ST_DONE, 32'd0}},
      '{MODE_ALLOC, 32'h0000_3000,  27'h000_3000,  32'd0,          1'b0, '{ST_DONE, 32'd0}},
      '{MODE_ALLOC, 32'h0000_2000,  27'h000_0800,  32'd0,          1'b0, '{ST_DONE, 32'd0}},
      '{MODE_ALLOC, 32'h0000_1000,  27'h400_0000,  32'd0,          1'b0, '{ST_DONE, 32'd0}},
      '{MODE_FREE,  32'h0001_0FFF,  27'd0,         32'h0100_3ABC,  1'b0, '{ST_DONE, 32'd0}},
      '{MODE_ALLOC, 32'h0000_0FFF,  27'h000_1000,  32'hFFFF_FFFF,  1'b0, '{ST_DONE, 32'd0}}
   };

   phase_type phases [5] = '{
      '{64,    350, 0, 1'b1},
      '{1,     70,  1, 1'b1},
      '{300,   350, 2, 1'b1},
      '{128,   350, 3, 1'b1},
      '{32767, 40,  0, 1'b0}
   };

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idling == 2) rsp_tready <= ($urandom_range(99) >= 59);
      else if (idling == 3) rsp_tready <= ($urandom_range(99) >= 31);
      else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            $error("unexpected beat: status %0d page_address %h", rsp_tuser, rsp_tdata);
            failed = 1'b1;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tdata !== want.page_address) begin
               $error("page_address: expected %h, actual %h", want.page_address, rsp_tdata);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic offer_request(logic mode, logic [31:0] size, logic [26:0] alb,
                                logic [31:0] saddr, bit fixed, grant_type fixed_grant);
      grant_type g;
      int        idle_pct;
      idle_pct = (idling == 1) ? 59 : ((idling == 3) ? 31 : 0);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {5'b0, saddr, alb, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = serve_request(mode, size, alb, saddr);
      pending_grants.push_back(fixed ? fixed_grant : g);
   endtask

   task automatic drain_grants();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_page_limit(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_PAGE_LIMIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      page_limit_reg = value & 32'h7FFF;
   endtask

   task automatic random_request(int unsigned lim, bit noisy);
      logic        mode;
      logic [31:0] size, saddr;
      logic [26:0] alb;
      int unsigned pages, span;
      span  = (lim == 0) ? 1 : ((lim > MAP_PAGES) ? MAP_PAGES : lim);
      pages = $urandom_range(1, 6);
      mode  = ($urandom_range(99) < 55) ? MODE_ALLOC : MODE_FREE;
      saddr = $urandom;
      alb   = $urandom;
      if (noisy && $urandom_range(99) < 10) begin
         size = $urandom;
      end else if (mode == MODE_ALLOC) begin
         size = (pages - 1) * 4096 + $urandom_range(1, 4096);
         if ($urandom_range(99) < 5) size = 0;
         alb = ($urandom_range(99) < 10) ? 27'd0 : 27'(1 << $urandom_range(0, 16));
      end else begin
         size  = pages * 4096 + $urandom_range(0, 4095);
         saddr = ($urandom_range(0, span - 1) << PG_BITS) | $urandom_range(0, 4095);
      end
      offer_request(mode, size, alb, saddr, 1'b0, '{ST_DONE, 32'd0});
   endtask

   initial begin
      for (int p = 0; p < MAP_PAGES; p++) used_map[p] = (p < BOOT_PAGES);
      next_fit       = BOOT_PAGES - 1;
      page_limit_reg = MAP_PAGES;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_page_limit(MAP_PAGES);
      foreach (directed_rows[i])
         offer_request(directed_rows[i].mode, directed_rows[i].byte_size,
                       directed_rows[i].align_bytes, directed_rows[i].start_address,
                       directed_rows[i].fixed, directed_rows[i].fixed_grant);
      drain_grants();
      foreach (phases[k]) begin
         idling = phases[k].idling;
         write_page_limit(phases[k].limit);
         if (k == 0) hold_request = 1'b1;
         for (int n = 0; n < phases[k].items; n++)
            random_request(phases[k].limit, phases[k].noisy);
         drain_grants();
      end
      repeat (50) @(posedge clock);
      if (!failed && pending_grants.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
